// ===== rtl/spirm_pkg.sv =====
package spirm_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  localparam logic [7:0] SHIFT_IDLE = 8'hFF;
  localparam logic [2:0] LAST_BIT   = 3'd7;

  // Request payload as seen on the input channel
  typedef struct packed {
    logic [1:0] cmd;
    logic       is_write;
    logic [6:0] address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       miso;
  } req_t;

  // Result payload as seen on the output channel
  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic       cs_n;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_byte;
    logic       want_byte;
    logic       busy_res;
    logic       start_error;
  } rsp_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_START_BAD,
    OP_LOAD,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       is_write;
    logic [7:0] addr_byte;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       miso;
  } item_t;

endpackage

// ===== rtl/spirm_if.sv =====
interface spirm_req_if import spirm_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface spirm_rsp_if import spirm_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/spirm_front.sv =====
module spirm_front import spirm_pkg::*; (
  spirm_req_if.sink req,
  input  logic      full,
  output logic      push,
  output item_t     item
);

  assign req.ready = !full;
  assign push      = req.valid && !full;

  // Decode the command and flag zero-length starts up front
  always_comb begin
    item.is_write   = req.payload.is_write;
    item.addr_byte  = {req.payload.is_write, req.payload.address};
    item.byte_count = req.payload.byte_count;
    item.write_byte = req.payload.write_byte;
    item.miso       = req.payload.miso;
    unique case (req.payload.cmd)
      CMD_TICK:  item.op = OP_TICK;
      CMD_START: item.op = (req.payload.byte_count == 8'd0) ? OP_START_BAD : OP_START;
      CMD_LOAD:  item.op = OP_LOAD;
      default:   item.op = OP_NOP;
    endcase
  end

endmodule

// ===== rtl/spirm_queue.sv =====
module spirm_queue import spirm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  not_empty,
  output logic  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/spirm_back.sv =====
module spirm_back import spirm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        item_valid,
  output logic        pop,
  spirm_rsp_if.source rsp
);

  logic       active,          active_next;
  logic       write_mode,      write_mode_next;
  logic       half_phase,      half_phase_next;
  logic [2:0] bit_counter,     bit_counter_next;
  logic [7:0] bytes_left,      bytes_left_next;
  logic       in_addr_byte,    in_addr_byte_next;
  logic [7:0] out_shift,       out_shift_next;
  logic [7:0] in_shift,        in_shift_next;
  logic       held_valid,      held_valid_next;
  logic [7:0] bytes_dec;
  logic       waiting;
  logic       waiting_next;
  rsp_t       result;
  logic       out_valid;
  rsp_t       out_data;

  assign pop       = item_valid && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.payload = out_data;

  assign bytes_dec = bytes_left - 8'd1;
  assign waiting   = active && write_mode && !in_addr_byte && !held_valid;

  always_comb begin
    active_next       = active;
    write_mode_next   = write_mode;
    half_phase_next   = half_phase;
    bit_counter_next  = bit_counter;
    bytes_left_next   = bytes_left;
    in_addr_byte_next = in_addr_byte;
    out_shift_next    = out_shift;
    in_shift_next     = in_shift;
    held_valid_next   = held_valid;
    result            = '0;

    unique case (item.op)
      OP_START: begin
        if (active) begin
          result.start_error = 1'b1;
        end else begin
          active_next       = 1'b1;
          write_mode_next   = item.is_write;
          half_phase_next   = 1'b0;
          bit_counter_next  = '0;
          bytes_left_next   = item.byte_count;
          in_addr_byte_next = 1'b1;
          out_shift_next    = item.addr_byte;
          in_shift_next     = '0;
          held_valid_next   = 1'b0;
        end
      end
      OP_START_BAD: begin
        result.start_error = 1'b1;
      end
      OP_LOAD: begin
        if (waiting) begin
          held_valid_next = 1'b1;
          out_shift_next  = item.write_byte;
        end
      end
      OP_TICK: begin
        if (active && !waiting) begin
          if (!half_phase) begin
            // rising half: sample miso
            half_phase_next = 1'b1;
            in_shift_next   = {in_shift[6:0], item.miso};
          end else begin
            // falling half: advance mosi, close the byte on its last bit
            half_phase_next  = 1'b0;
            out_shift_next   = {out_shift[6:0], 1'b1};
            bit_counter_next = bit_counter + 3'd1;
            if (bit_counter == LAST_BIT) begin
              if (in_addr_byte) begin
                in_addr_byte_next = 1'b0;
                if (!write_mode) begin
                  out_shift_next = SHIFT_IDLE;
                end
              end else begin
                bytes_left_next = bytes_dec;
                if (write_mode) begin
                  held_valid_next = 1'b0;
                end else begin
                  result.read_byte  = in_shift;
                  result.read_valid = 1'b1;
                  result.last_byte  = (bytes_dec == 8'd0);
                end
                if (bytes_dec == 8'd0) begin
                  active_next    = 1'b0;
                  out_shift_next = SHIFT_IDLE;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase

    waiting_next = active_next && write_mode_next && !in_addr_byte_next && !held_valid_next;

    result.sck       = active_next && half_phase_next;
    result.mosi      = active_next ? out_shift_next[7] : 1'b1;
    result.cs_n      = !active_next;
    result.want_byte = waiting_next;
    result.busy_res  = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      write_mode   <= 1'b0;
      half_phase   <= 1'b0;
      bit_counter  <= '0;
      bytes_left   <= '0;
      in_addr_byte <= 1'b0;
      out_shift    <= SHIFT_IDLE;
      in_shift     <= '0;
      held_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        active       <= active_next;
        write_mode   <= write_mode_next;
        half_phase   <= half_phase_next;
        bit_counter  <= bit_counter_next;
        bytes_left   <= bytes_left_next;
        in_addr_byte <= in_addr_byte_next;
        out_shift    <= out_shift_next;
        in_shift     <= in_shift_next;
        held_valid   <= held_valid_next;
        out_valid    <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/spi_register_access_master_unit.sv =====
// SPI mode-0 register access master, MSB first.
//
// Input channel (req): one transfer per command. A tick advances the serial
// engine by one half bit period, a start opens a read or write transaction
// (address byte, then byte_count data bytes), a load supplies the next write
// byte while want_byte is set. Rejected starts (busy or zero count) return
// start_error and leave the engine untouched.
// Output channel (rsp): exactly one transfer per accepted command, carrying
// the pin levels (sck, mosi, cs_n) after that command, any completed read
// byte with its last-byte mark, and the status flags.
//
// Flow: a command is decoded and parked in a small queue on the edge it
// is accepted, then executed by the engine, which also loads its result
// into the output register to be offered on rsp.
// Throughput: one command per cycle while rsp does not stall.
// If rsp stalls, the engine holds and the queue absorbs up to QUEUE_DEPTH
// commands before req.ready drops; nothing is lost or repeated.
// Reset (synchronous, active high) empties the queue and output register
// and returns the engine to idle: cs_n high, sck low, mosi high.
module spi_register_access_master_unit import spirm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  spirm_req_if.sink   req,
  spirm_rsp_if.source rsp
);

  item_t front_item;
  item_t queue_head;
  logic  push;
  logic  pop;
  logic  queue_full;
  logic  queue_not_empty;

  // Front: accept and classify commands
  spirm_front u_front (
    .req  (req),
    .full (queue_full),
    .push (push),
    .item (front_item)
  );

  // Decouple decode from execution so each side stalls on its own
  spirm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (queue_head),
    .not_empty (queue_not_empty),
    .full      (queue_full)
  );

  // Back: serial engine and registered result
  spirm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (queue_head),
    .item_valid (queue_not_empty),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
